>>> rtl/core/gsm7_septet_unpacker_top_assert.svh
// ----------------------------------------------------------------------------
// GSM7 septet unpacker assertion macros
// Concurrent assertion helpers shared by the unpacker RTL.
// ----------------------------------------------------------------------------
`ifndef GSM7_SEPTET_UNPACKER_TOP_ASSERT_SVH
`define GSM7_SEPTET_UNPACKER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define GSM7SU_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// A consequent that must hold in the cycle after its antecedent.
`define GSM7SU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/gsm7su_pkg.sv
// ----------------------------------------------------------------------------
// GSM7 septet unpacker package
// Alphabet tables, lookup function and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsm7su_pkg;

    localparam int unsigned OCTET_W = 8;
    localparam int unsigned SEPTET_W = 7;
    localparam int unsigned CP_W = 16;
    localparam logic [SEPTET_W-1:0] ESCAPE_CODE = 7'h1B;
    localparam logic [2:0] LAST_OFFSET = 3'd6;

    localparam logic [CP_W-1:0] DEF_ALPHABET [128] = '{
        16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
        16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
        16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
        16'h03A3, 16'h0398, 16'h039E, 16'h001B, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
        16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
    };

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] cp;
        logic            esc_next;
    } dec_t;

    // Decodes one septet given the escape state in front of it.
    function automatic dec_t decode_septet(input logic [SEPTET_W-1:0] sep, input logic esc);
        dec_t d;
        d.valid = 1'b0;
        d.cp = '0;
        d.esc_next = 1'b0;
        if (esc) begin
            d.valid = 1'b1;
            case (sep)
                7'h0A: d.cp = 16'h000C;
                7'h14: d.cp = 16'h005E;
                7'h28: d.cp = 16'h007B;
                7'h29: d.cp = 16'h007D;
                7'h2F: d.cp = 16'h005C;
                7'h3C: d.cp = 16'h005B;
                7'h3D: d.cp = 16'h007E;
                7'h3E: d.cp = 16'h005D;
                7'h40: d.cp = 16'h007C;
                7'h65: d.cp = 16'h20AC;
                default: d.valid = 1'b0;
            endcase
        end else if (sep == ESCAPE_CODE) begin
            d.esc_next = 1'b1;
        end else begin
            d.valid = 1'b1;
            d.cp = DEF_ALPHABET[sep];
        end
        return d;
    endfunction

endpackage

>>> rtl/core/gsm7_septet_unpacker_top.sv
// ----------------------------------------------------------------------------
// GSM7 septet unpacker
// Unpacks SMS 7-bit user data octets into Unicode code points.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one packed user-data octet per beat on s_tdata.
// s_tuser high marks the first octet of a message; it clears the bit offset,
// the carried bits and any pending escape before that octet is unpacked.
// The master channel delivers one 16-bit code point per beat on m_tdata, and
// m_tlast is high on the last character that a given octet produced.
// An octet yields zero, one or two characters: every seventh octet completes
// a second septet, an escape septet yields nothing itself, and an unknown
// escaped code is dropped.
// The output is registered: characters of an octet accepted at one edge appear
// on the master side right after it. The decode is a single pass of shift,
// table lookup and escape logic from the accepted beat into a two-entry
// output buffer. One octet per cycle is sustained while each octet gives at
// most one character and m_tready stays high; an octet that gives two
// characters holds s_tready low until the first of the two has been taken.
// s_tready is high whenever the buffer will be empty after this cycle's
// output beat, so a stalled receiver simply holds back the slave channel.
// Reset (aresetn low at a clock edge) empties the buffer and clears the
// unpacker state.
`timescale 1ns / 1ps

module gsm7_septet_unpacker_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gsm7su_pkg::OCTET_W-1:0] s_tdata,  // [7:0] octet
    input  logic                          s_tuser,  // [0] first_of_message
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gsm7su_pkg::CP_W-1:0]   m_tdata,  // [15:0] code_point
    output logic                          m_tlast   // last_of_run
);

    import gsm7su_pkg::*;

    // Unpacker state.
    logic [2:0]          bit_offset_reg, bit_offset_next;
    logic [SEPTET_W-1:0] carry_reg, carry_next;
    logic                esc_reg, esc_next;

    // Two-entry output buffer; slot 0 is the head shown on the master side.
    logic [1:0]      cnt_reg, cnt_next;
    logic [CP_W-1:0] cp0_reg, cp0_next, cp1_reg, cp1_next;
    logic            last0_reg, last0_next, last1_reg, last1_next;

    logic                in_acc, out_acc;
    logic [2:0]          off_eff, shift;
    logic [SEPTET_W-1:0] carry_eff;
    logic                esc_eff;
    logic [SEPTET_W-1:0] shifted;
    logic [SEPTET_W-1:0] high_part;
    logic [SEPTET_W-1:0] sep0, sep1;
    logic                two_sep;
    dec_t                dec0, dec1;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = cp0_reg;
    assign m_tlast  = last0_reg;
    assign out_acc  = m_tvalid && m_tready;
    // Accept only when the buffer is certain to be empty after this edge.
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign in_acc   = s_tvalid && s_tready;

    always_comb begin
        off_eff   = s_tuser ? 3'd0 : bit_offset_reg;
        carry_eff = s_tuser ? '0 : carry_reg;
        esc_eff   = s_tuser ? 1'b0 : esc_reg;
        // An offset of seven cannot arise normally and is read as zero.
        shift     = (off_eff == 3'd7) ? 3'd0 : off_eff;
        two_sep   = (shift == LAST_OFFSET);
        // Low bits of the octet complete the carried septet; the bits above
        // them become the new carry, or a whole second septet at offset six.
        shifted   = SEPTET_W'(s_tdata << shift);
        high_part = SEPTET_W'(s_tdata >> (3'd7 - shift));
        sep0      = carry_eff | shifted;
        sep1      = high_part;
        dec0      = decode_septet(sep0, esc_eff);
        dec1      = decode_septet(sep1, dec0.esc_next);
        if (!two_sep) begin
            dec1.valid = 1'b0;
        end

        bit_offset_next = bit_offset_reg;
        carry_next      = carry_reg;
        esc_next        = esc_reg;
        cnt_next        = cnt_reg;
        cp0_next        = cp0_reg;
        cp1_next        = cp1_reg;
        last0_next      = last0_reg;
        last1_next      = last1_reg;

        if (out_acc) begin
            cnt_next   = cnt_reg - 2'd1;
            cp0_next   = cp1_reg;
            last0_next = last1_reg;
        end

        if (in_acc) begin
            if (two_sep) begin
                bit_offset_next = 3'd0;
                carry_next      = '0;
                esc_next        = dec1.esc_next;
            end else begin
                bit_offset_next = shift + 3'd1;
                carry_next      = sep1;
                esc_next        = dec0.esc_next;
            end
            if (dec0.valid && dec1.valid) begin
                cnt_next   = 2'd2;
                cp0_next   = dec0.cp;
                last0_next = 1'b0;
                cp1_next   = dec1.cp;
                last1_next = 1'b1;
            end else if (dec0.valid) begin
                cnt_next   = 2'd1;
                cp0_next   = dec0.cp;
                last0_next = 1'b1;
            end else if (dec1.valid) begin
                cnt_next   = 2'd1;
                cp0_next   = dec1.cp;
                last0_next = 1'b1;
            end else begin
                cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_offset_reg <= 3'd0;
            carry_reg      <= '0;
            esc_reg        <= 1'b0;
            cnt_reg        <= 2'd0;
        end else begin
            bit_offset_reg <= bit_offset_next;
            carry_reg      <= carry_next;
            esc_reg        <= esc_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp0_reg   <= cp0_next;
        cp1_reg   <= cp1_next;
        last0_reg <= last0_next;
        last1_reg <= last1_next;
    end

`include "gsm7_septet_unpacker_top_assert.svh"

    // The buffer never holds more than the two characters of one octet.
    `GSM7SU_ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3)
    // With two entries queued, the head is not the last of its octet.
    `GSM7SU_ASSERT_ALWAYS(a_head_not_last, aclk, aresetn, (cnt_reg != 2'd2) || !last0_reg)
    // A single queued entry always closes its octet's run.
    `GSM7SU_ASSERT_ALWAYS(a_single_last, aclk, aresetn, (cnt_reg != 2'd1) || last0_reg)
    // After any accepted octet the bit offset is a legal value.
    `GSM7SU_ASSERT_NEXT(a_offset_legal, aclk, aresetn, in_acc, bit_offset_reg != 3'd7)

endmodule

>>> sim/gsm7_septet_unpacker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GSM7 septet unpacker testbench
// Streams packed SMS octets into the unpacker. A built-in model predicts every
// code point and compares it with each master-side beat, under random stalls.
// ----------------------------------------------------------------------------

module gsm7_septet_unpacker_top_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_OCTETS = 1000;

    localparam logic [6:0] ESC_SEPTET = 7'h1B;

    // Published default alphabet, indexed by septet value.
    localparam logic [15:0] GSM_DEFAULT [128] = '{
        16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
        16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
        16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
        16'h03A3, 16'h0398, 16'h039E, 16'h001B, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
        16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
    };

    // Extension table: septet after an escape and the character it selects.
    localparam logic [6:0] EXT_KEYS [10] = '{
        7'h0A, 7'h14, 7'h28, 7'h29, 7'h2F, 7'h3C, 7'h3D, 7'h3E, 7'h40, 7'h65
    };
    localparam logic [15:0] EXT_CHARS [10] = '{
        16'h000C, 16'h005E, 16'h007B, 16'h007D, 16'h005C, 16'h005B, 16'h007E,
        16'h005D, 16'h007C, 16'h20AC
    };

    // Escape corner cases as one septet stream: the euro sign, a doubled
    // escape that is dropped, an unknown escaped code that is dropped, the
    // two corrected default entries, a known escape and the top septet.
    localparam logic [6:0] ESCAPE_STREAM [12] = '{
        7'h1B, 7'h65, 7'h1B, 7'h1B, 7'h1B, 7'h00, 7'h1D, 7'h1F,
        7'h1B, 7'h40, 7'h7F, 7'h00
    };

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [gsm7su_pkg::OCTET_W-1:0] s_tdata = '0;   // [7:0] octet
    logic                          s_tuser = 1'b0;  // [0] first_of_message
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [gsm7su_pkg::CP_W-1:0]   m_tdata;         // [15:0] code_point
    logic                          m_tlast;         // last_of_run

    // Predicted unpacker state.
    logic [2:0] unp_offset = '0;
    logic [6:0] unp_carry = '0;
    logic       unp_escape = 1'b0;

    // Characters still owed by the block, oldest first.
    logic [15:0] expected_cp [$];
    logic        expected_last [$];

    logic [6:0] msg_septets [$];

    int  mismatches = 0;
    int  cycles = 0;
    int  octets_sent = 0;
    int  rx_hold_left = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    gsm7_septet_unpacker_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Watchdog: a hung handshake or a missing character ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Advances the predicted state by one accepted octet and queues the
    // characters it yields, the last of them flagged.
    task automatic unpack_octet(input logic [7:0] oct, input logic first);
        logic [2:0]  sh;
        logic [15:0] wide;
        logic [6:0]  seps [2];
        logic [15:0] chars [2];
        logic [6:0]  sep;
        int          nsep;
        int          nchar;
        int          k;
        int          j;
        if (first) begin
            unp_offset = '0;
            unp_carry = '0;
            unp_escape = 1'b0;
        end
        sh = unp_offset;
        if (sh > 3'd6) begin
            sh = 3'd0;
        end
        wide = {8'h00, oct} << sh;
        seps[0] = unp_carry | wide[6:0];
        wide = {8'h00, oct} >> (7 - int'(sh));
        unp_carry = wide[6:0];
        nsep = 1;
        if (sh == 3'd6) begin
            // Seven octets hold eight septets: the carry is a whole septet now.
            seps[1] = unp_carry;
            nsep = 2;
            unp_carry = '0;
            unp_offset = '0;
        end else begin
            unp_offset = sh + 3'd1;
        end
        nchar = 0;
        for (k = 0; k < nsep; k++) begin
            sep = seps[k];
            if (unp_escape) begin
                unp_escape = 1'b0;
                for (j = 0; j < 10; j++) begin
                    if (EXT_KEYS[j] == sep) begin
                        chars[nchar] = EXT_CHARS[j];
                        nchar++;
                    end
                end
            end else if (sep == ESC_SEPTET) begin
                unp_escape = 1'b1;
            end else begin
                chars[nchar] = GSM_DEFAULT[sep];
                nchar++;
            end
        end
        for (k = 0; k < nchar; k++) begin
            expected_cp.push_back(chars[k]);
            expected_last.push_back(k == nchar - 1);
        end
    endtask

    task automatic check_char(input logic [15:0] cp, input logic last);
        logic [15:0] want_cp;
        logic        want_last;
        if (expected_cp.size() == 0) begin
            if (mismatches < MAX_REPORTS) begin
                $display("unexpected character: code point %h last %b", cp, last);
            end
            mismatches++;
        end else begin
            want_cp = expected_cp.pop_front();
            want_last = expected_last.pop_front();
            if (cp !== want_cp || last !== want_last) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("mismatch: expected code point %h last %b, got %h last %b",
                             want_cp, want_last, cp, last);
                end
                mismatches++;
            end
        end
    endtask

    // Monitor: prediction is taken first so that a same-edge result still
    // finds its expectation in the queue.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                unpack_octet(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                check_char(m_tdata, m_tlast);
            end
        end
    end

    // Long receiver hold-off, counted down here once a test arms it.
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Receiver: a random wait ahead of every beat while idles are enabled.
    initial begin : receiver
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (gap > 0 || rx_hold_left > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                while (rx_hold_left > 0) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offers one octet after a random gap and returns once it is taken.
    task automatic send_octet(input logic [7:0] oct, input logic first);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= oct;
        s_tuser <= first;
        do @(posedge aclk); while (!s_tready);
        octets_sent++;
    endtask

    // Packs msg_septets least significant bit first, zero fill in the last
    // octet, and sends them as one message.
    task automatic send_message();
        logic [7:0] oct;
        int         nbits;
        int         i;
        int         b;
        int         idx;
        nbits = 7 * msg_septets.size();
        for (i = 0; i < (nbits + 7) / 8; i++) begin
            oct = 8'h00;
            for (b = 0; b < 8; b++) begin
                idx = i * 8 + b;
                if (idx < nbits) begin
                    oct[b] = msg_septets[idx / 7][idx % 7];
                end
            end
            send_octet(oct, i == 0);
        end
        msg_septets.delete();
    endtask

    // A well-formed message with random text; escapes are frequent and are
    // mostly followed by a valid extension code.
    task automatic random_message(input int len);
        logic [6:0] sep;
        logic       esc;
        int         i;
        esc = 1'b0;
        for (i = 0; i < len; i++) begin
            if (esc) begin
                if ($urandom_range(0, 9) < 7) begin
                    sep = EXT_KEYS[$urandom_range(0, 9)];
                end else begin
                    sep = 7'($urandom_range(0, 127));
                end
                esc = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                sep = ESC_SEPTET;
                esc = 1'b1;
            end else begin
                sep = 7'($urandom_range(0, 127));
                esc = (sep == ESC_SEPTET);
            end
            msg_septets.push_back(sep);
        end
        send_message();
    endtask

    // Mostly messages of typical length, some up to a full SMS, and some
    // raw octets with stray first-of-message flags that cut sequences.
    task automatic random_traffic(input int n_octets);
        int stop_at;
        int i;
        int pick;
        stop_at = octets_sent + n_octets;
        while (octets_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                random_message($urandom_range(1, 24));
            end else if (pick < 8) begin
                random_message($urandom_range(25, 160));
            end else begin
                for (i = $urandom_range(1, 10); i > 0; i--) begin
                    send_octet(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    // Stops offering and waits until every owed character has arrived, then
    // a further drain wait in case the block is still busy.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_cp.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // All-zero and all-one octets, running through offset six so that the
    // seventh octet yields two characters, then a restart mid-stream.
    task automatic test_octet_extremes();
        int i;
        send_octet(8'h00, 1'b1);
        for (i = 0; i < 7; i++) begin
            send_octet(8'hFF, 1'b0);
        end
        send_octet(8'hFF, 1'b1);
        wait_drain();
    endtask

    // Escape handling, then an escape left pending at the end of a message
    // that the next first-of-message flag must clear.
    task automatic test_escape_cases();
        int i;
        for (i = 0; i < 12; i++) begin
            msg_septets.push_back(ESCAPE_STREAM[i]);
        end
        send_message();
        msg_septets.push_back(ESC_SEPTET);
        send_message();
        msg_septets.push_back(7'h0A);
        msg_septets.push_back(ESC_SEPTET);
        msg_septets.push_back(7'h65);
        send_message();
        wait_drain();
    endtask

    task automatic test_random_stream();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        random_traffic(RANDOM_OCTETS);
        wait_drain();
    endtask

    // The receiver stalls for a long stretch while octets keep coming, so
    // the output buffer fills and the block must hold back s_tready.
    task automatic test_receiver_hold();
        tx_idle_on = 1'b0;
        rx_hold_left <= 300;
        random_traffic(60);
        wait_drain();
    endtask

    // Back-to-back beats on both sides.
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_traffic(100);
        wait_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_octet_extremes();
        test_escape_cases();
        test_random_stream();
        test_receiver_hold();
        test_full_rate();
        if (mismatches == 0 && expected_cp.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
